/* design/cpsa_pkg.sv */
// cpsa_pkg: shared types and constants of the complex postfix stack alu
// no dependencies; compiled first

package cpsa_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int DATA_W          = 64;
  localparam int CMD_W           = 3;
  localparam int DEPTH_OUT_W     = 7;
  localparam int HALF_W          = DATA_W / 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 3'd0,
    CMD_ADD  = 3'd1,
    CMD_SUB  = 3'd2,
    CMD_MUL  = 3'd3,
    CMD_NEG  = 3'd4,
    CMD_CONJ = 3'd5,
    CMD_STOP = 3'd6,
    CMD_NOP  = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL
  } state_t;

  typedef struct packed {
    logic [DATA_W-1:0] re;
    logic [DATA_W-1:0] im;
  } cplx_t;

endpackage

/* design/cpsa_if.sv */
// cpsa_if: valid/ready channels for commands and results
// depends on cpsa_pkg

interface cpsa_cmd_if;
  logic                                   valid;
  logic                                   ready;
  logic [cpsa_pkg::CMD_W-1:0]             command;
  logic signed [cpsa_pkg::DATA_W-1:0]     real_in;
  logic signed [cpsa_pkg::DATA_W-1:0]     imag_in;

  modport source (output valid, command, real_in, imag_in, input ready);
  modport sink   (input valid, command, real_in, imag_in, output ready);
endinterface

interface cpsa_res_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [cpsa_pkg::DATA_W-1:0]     real_out;
  logic signed [cpsa_pkg::DATA_W-1:0]     imag_out;
  logic [cpsa_pkg::DEPTH_OUT_W-1:0]       depth_out;
  logic                                   stack_empty;
  logic                                   error_seen;

  modport source (output valid, real_out, imag_out, depth_out, stack_empty, error_seen,
                  input ready);
  modport sink   (input valid, real_out, imag_out, depth_out, stack_empty, error_seen,
                  output ready);
endinterface

/* design/cpsa_stack_mem.sv */
// cpsa_stack_mem: stack storage, one write port and two registered read ports
// depends on cpsa_pkg

module cpsa_stack_mem #(
  parameter int DEPTH = cpsa_pkg::STACK_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  cpsa_pkg::cplx_t wdata,
  input  logic           re,
  input  logic [AW-1:0]  raddr_top,
  input  logic [AW-1:0]  raddr_next,
  output cpsa_pkg::cplx_t rdata_top,
  output cpsa_pkg::cplx_t rdata_next
);
  import cpsa_pkg::*;

  cplx_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_top  <= mem[raddr_top];
      rdata_next <= mem[raddr_next];
    end
  end

endmodule

/* design/cpsa_cmul.sv */
// cpsa_cmul: complex product modulo 2^64 on one shared 32x32 multiplier
// depends on cpsa_pkg

module cpsa_cmul (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  cpsa_pkg::cplx_t a,
  input  cpsa_pkg::cplx_t b,
  output logic            done,
  output cpsa_pkg::cplx_t prod
);
  import cpsa_pkg::*;

  cplx_t             a_l;
  cplx_t             b_l;
  logic              busy;
  logic [1:0]        prod_idx;
  logic [1:0]        part_idx;
  logic [DATA_W-1:0] x;
  logic [DATA_W-1:0] y;
  logic [HALF_W-1:0] mx;
  logic [HALF_W-1:0] my;
  logic [DATA_W-1:0] p;
  logic [1:0]        p_prod;
  logic [1:0]        p_part;
  logic              p_valid;
  logic              p_last;
  logic [DATA_W-1:0] term;
  logic              last_step;

  // products: re*re, im*im (subtracted), re*im, im*re
  always_comb begin
    case (prod_idx)
      2'd0:    begin x = a_l.re; y = b_l.re; end
      2'd1:    begin x = a_l.im; y = b_l.im; end
      2'd2:    begin x = a_l.re; y = b_l.im; end
      default: begin x = a_l.im; y = b_l.re; end
    endcase
    case (part_idx)
      2'd0:    begin mx = x[HALF_W-1:0];      my = y[HALF_W-1:0];      end
      2'd1:    begin mx = x[HALF_W-1:0];      my = y[DATA_W-1:HALF_W]; end
      default: begin mx = x[DATA_W-1:HALF_W]; my = y[HALF_W-1:0];      end
    endcase
    last_step = (prod_idx == 2'd3) && (part_idx == 2'd2);
    term = (p_part == 2'd0) ? p : {p[HALF_W-1:0], {HALF_W{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      prod_idx <= '0;
      part_idx <= '0;
      p_valid  <= 1'b0;
      p_last   <= 1'b0;
      done     <= 1'b0;
    end else begin
      done    <= p_valid && p_last;
      p_valid <= busy;
      p_last  <= busy && last_step;
      if (start) begin
        busy     <= 1'b1;
        prod_idx <= '0;
        part_idx <= '0;
      end else if (busy) begin
        if (part_idx == 2'd2) begin
          part_idx <= '0;
          prod_idx <= prod_idx + 2'd1;
          if (last_step) begin
            busy <= 1'b0;
          end
        end else begin
          part_idx <= part_idx + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    p      <= DATA_W'(mx * my);
    p_prod <= prod_idx;
    p_part <= part_idx;
    if (start) begin
      a_l     <= a;
      b_l     <= b;
      prod.re <= '0;
      prod.im <= '0;
    end else if (p_valid) begin
      case (p_prod)
        2'd0:    prod.re <= prod.re + term;
        2'd1:    prod.re <= prod.re - term;
        default: prod.im <= prod.im + term;
      endcase
    end
  end

endmodule

/* design/complex_postfix_stack_alu.sv */
// complex_postfix_stack_alu: postfix calculator for complex integers
// depends on cpsa_pkg, cpsa_if, cpsa_stack_mem, cpsa_cmul
//
//   channel | dir | payload                                           | transfer
//   cmd     | in  | command, real_in, imag_in                         | valid & ready
//   res     | out | real_out, imag_out, depth_out, stack_empty,       | valid & ready
//           |     | error_seen                                        |
//
// push, add, subtract, negate, conjugate, no-op: memory read then write back
// multiply: twelve 32x32 partial products through one shared multiplier
// stop: waits while the previous result is still held in the output register
// reset clears the depth count, the error flag and the output valid flag; no clearing pass
// cmd.ready is high only between commands; res stalls hold the block only on stop

module complex_postfix_stack_alu #(
  parameter int STACK_DEPTH = cpsa_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  cpsa_cmd_if.sink    cmd,
  cpsa_res_if.source  res
);
  import cpsa_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  state_t            state;
  state_t            state_next;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic              err;
  logic              err_next;
  cmd_t              op;
  cplx_t             in_l;
  logic              accept;
  logic              we;
  logic [AW-1:0]     waddr;
  cplx_t             wdata;
  cplx_t             q_top;
  cplx_t             q_next;
  logic [AW-1:0]     top_addr;
  logic [AW-1:0]     next_addr;
  logic              mul_start;
  logic              mul_done;
  cplx_t             mul_prod;
  logic              out_load;
  logic              out_valid;

  assign accept    = cmd.valid && cmd.ready;
  assign cmd.ready = (state == ST_IDLE) && !rst;
  assign top_addr  = AW'(count - CW'(1));
  assign next_addr = AW'(count - CW'(2));

  cpsa_stack_mem #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk        (clk),
    .we         (we),
    .waddr      (waddr),
    .wdata      (wdata),
    .re         (accept),
    .raddr_top  (top_addr),
    .raddr_next (next_addr),
    .rdata_top  (q_top),
    .rdata_next (q_next)
  );

  cpsa_cmul u_cmul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (q_top),
    .b     (q_next),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      err   <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      err   <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op      <= cmd_t'(cmd.command);
      in_l.re <= cmd.real_in;
      in_l.im <= cmd.imag_in;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    err_next   = err;
    we         = 1'b0;
    waddr      = top_addr;
    wdata      = q_top;
    mul_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
        case (op)
          CMD_PUSH: begin
            if (count >= CW'(STACK_DEPTH)) begin
              err_next = 1'b1;
            end else begin
              we         = 1'b1;
              waddr      = AW'(count);
              wdata      = in_l;
              count_next = count + CW'(1);
            end
          end
          CMD_ADD, CMD_SUB: begin
            if (count < CW'(2)) begin
              err_next = 1'b1;
            end else begin
              we         = 1'b1;
              waddr      = next_addr;
              count_next = count - CW'(1);
              if (op == CMD_ADD) begin
                wdata.re = q_top.re + q_next.re;
                wdata.im = q_top.im + q_next.im;
              end else begin
                wdata.re = q_top.re - q_next.re;
                wdata.im = q_top.im - q_next.im;
              end
            end
          end
          CMD_MUL: begin
            if (count < CW'(2)) begin
              err_next = 1'b1;
            end else begin
              mul_start  = 1'b1;
              state_next = ST_MUL;
            end
          end
          CMD_NEG, CMD_CONJ: begin
            if (count == '0) begin
              err_next = 1'b1;
            end else begin
              we       = 1'b1;
              waddr    = top_addr;
              wdata.im = '0 - q_top.im;
              if (op == CMD_NEG) begin
                wdata.re = '0 - q_top.re;
              end
            end
          end
          CMD_STOP: begin
            if (!out_valid || res.ready) begin
              out_load   = 1'b1;
              count_next = '0;
              err_next   = 1'b0;
            end else begin
              state_next = ST_EXEC;
            end
          end
          default: ;
        endcase
      end
      ST_MUL: begin
        if (mul_done) begin
          we         = 1'b1;
          waddr      = next_addr;
          wdata      = mul_prod;
          count_next = count - CW'(1);
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res.stack_empty <= (count == '0);
      res.real_out    <= (count == '0) ? '0 : q_top.re;
      res.imag_out    <= (count == '0) ? '0 : q_top.im;
      res.depth_out   <= DEPTH_OUT_W'(count);
      res.error_seen  <= err;
    end
  end

  assign res.valid = out_valid;

endmodule

/* design/cpsa_checker.sv */
// cpsa_checker: port-level checks of the complex postfix stack alu
// depends on cpsa_pkg; bound to complex_postfix_stack_alu

module cpsa_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [cpsa_pkg::DATA_W-1:0]         real_out,
  input logic [cpsa_pkg::DATA_W-1:0]         imag_out,
  input logic [cpsa_pkg::DEPTH_OUT_W-1:0]    depth_out,
  input logic                                stack_empty,
  input logic                                error_seen
);
  import cpsa_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(real_out) && $stable(imag_out)
      && $stable(depth_out) && $stable(stack_empty) && $stable(error_seen))
    else $error("result changed while stalled");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && stack_empty |-> real_out == '0 && imag_out == '0 && depth_out == '0)
    else $error("empty stop with nonzero payload");

  a_nonempty_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid && !stack_empty |-> depth_out != '0)
    else $error("nonempty stop with zero depth");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken while previous one in progress");

endmodule

bind complex_postfix_stack_alu cpsa_checker u_cpsa_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (cmd.valid),
  .in_ready    (cmd.ready),
  .out_valid   (res.valid),
  .out_ready   (res.ready),
  .real_out    (res.real_out),
  .imag_out    (res.imag_out),
  .depth_out   (res.depth_out),
  .stack_empty (res.stack_empty),
  .error_seen  (res.error_seen)
);
